// File: rtl/core/brsp_pkg.sv
// shared types and constants for the base relocation stream parser
// used by brsp_parser, brsp_result_fifo and base_relocation_stream_parser_top
`default_nettype none

package brsp_pkg;

    localparam int unsigned HEADER_BYTES = 8;
    localparam int unsigned TYPE_SHIFT   = 12;
    localparam logic [11:0] OFFSET_MASK  = 12'hFFF;

    typedef enum logic [1:0] {
        MODE_HEADER  = 2'd0,
        MODE_ENTRIES = 2'd1,
        MODE_STOPPED = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_ENTRY    = 2'd0,
        KIND_BAD_SIZE = 2'd1,
        KIND_END      = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  rtype;
        logic [31:0] addr;
        logic        last;
    } result_t;

    // results produced by one byte, first in r0
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

`default_nettype wire

// File: rtl/core/brsp_parser.sv
// input byte register, directory size register and per-byte parse state
// depends on brsp_pkg; pushes up to two results into brsp_result_fifo
`default_nettype none

module brsp_parser
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [31:0]   cfg_wdata,
    input  wire logic          byte_valid,
    output logic               byte_ready,
    input  wire logic [7:0]    byte_data,
    input  wire logic          room,
    output brsp_pkg::push_t    push
);
    import brsp_pkg::*;

    logic [31:0] dir_size_reg;
    logic        byte_valid_reg;
    logic [7:0]  byte_reg;

    mode_t       mode_reg, mode_next;
    logic [2:0]  hdr_idx_reg, hdr_idx_next;
    logic [31:0] page_base_reg, page_base_next;
    logic [31:0] block_len_reg, block_len_next;
    logic [31:0] bib_reg, bib_next;
    logic [32:0] consumed_reg, consumed_next;
    logic [7:0]  low_reg, low_next;

    logic        advance;
    logic        active;
    logic [32:0] consumed_sum;
    logic [31:0] bib_inc;
    logic [15:0] word;
    result_t     entry_res, end_res, bad_res;

    assign advance    = byte_valid_reg && room;
    assign byte_ready = !byte_valid_reg || advance;
    assign active     = advance && (dir_size_reg != 32'd0);

    assign word    = {byte_reg, low_reg};
    assign bib_inc = bib_reg + 32'd1;

    always_comb
    begin
        entry_res.kind  = KIND_ENTRY;
        entry_res.rtype = word[15:TYPE_SHIFT];
        entry_res.addr  = page_base_reg + {20'd0, word[11:0] & OFFSET_MASK};
        entry_res.last  = 1'b1;
        end_res.kind    = KIND_END;
        end_res.rtype   = 4'd0;
        end_res.addr    = 32'd0;
        end_res.last    = 1'b1;
        bad_res.kind    = KIND_BAD_SIZE;
        bad_res.rtype   = 4'd0;
        bad_res.addr    = 32'd0;
        bad_res.last    = 1'b1;
    end

    always_comb
    begin
        mode_next      = mode_reg;
        hdr_idx_next   = hdr_idx_reg;
        page_base_next = page_base_reg;
        block_len_next = block_len_reg;
        bib_next       = bib_reg;
        consumed_next  = consumed_reg;
        low_next       = low_reg;
        push.count     = 2'd0;
        push.r0        = end_res;
        push.r1        = end_res;
        consumed_sum   = consumed_reg + {1'b0, block_len_reg};

        if (active)
        begin
            unique case (mode_reg)
                MODE_HEADER:
                begin
                    case (hdr_idx_reg)
                        3'd0: page_base_next[7:0]   = byte_reg;
                        3'd1: page_base_next[15:8]  = byte_reg;
                        3'd2: page_base_next[23:16] = byte_reg;
                        3'd3: page_base_next[31:24] = byte_reg;
                        3'd4: block_len_next[7:0]   = byte_reg;
                        3'd5: block_len_next[15:8]  = byte_reg;
                        3'd6: block_len_next[23:16] = byte_reg;
                        default: block_len_next[31:24] = byte_reg;
                    endcase
                    bib_next     = {29'd0, hdr_idx_reg} + 32'd1;
                    hdr_idx_next = hdr_idx_reg + 3'd1;
                    if (hdr_idx_reg == 3'd7)
                    begin
                        consumed_sum = consumed_reg + {1'b0, block_len_next};
                        if (block_len_next < HEADER_BYTES)
                        begin
                            mode_next  = MODE_STOPPED;
                            push.count = 2'd1;
                            push.r0    = bad_res;
                        end
                        else if (block_len_next == HEADER_BYTES)
                        begin
                            // header-only block completes here
                            consumed_next = consumed_sum;
                            bib_next      = 32'd0;
                            if (consumed_sum >= {1'b0, dir_size_reg})
                            begin
                                mode_next  = MODE_STOPPED;
                                push.count = 2'd1;
                                push.r0    = end_res;
                            end
                        end
                        else
                        begin
                            mode_next = MODE_ENTRIES;
                        end
                    end
                end
                MODE_ENTRIES:
                begin
                    // header length is even, so the byte parity gives the entry half
                    if (!bib_reg[0])
                    begin
                        low_next = byte_reg;
                    end
                    else
                    begin
                        push.count = 2'd1;
                        push.r0    = entry_res;
                    end
                    bib_next = bib_inc;
                    if (bib_inc == block_len_reg)
                    begin
                        consumed_next = consumed_sum;
                        bib_next      = 32'd0;
                        hdr_idx_next  = 3'd0;
                        mode_next     = MODE_HEADER;
                        if (consumed_sum >= {1'b0, dir_size_reg})
                        begin
                            mode_next = MODE_STOPPED;
                            if (bib_reg[0])
                            begin
                                push.count   = 2'd2;
                                push.r0.last = 1'b0;
                                push.r1      = end_res;
                            end
                            else
                            begin
                                push.count = 2'd1;
                                push.r0    = end_res;
                            end
                        end
                    end
                end
                default:
                begin
                    // stopped: bytes are dropped
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_size_reg   <= 32'd0;
            byte_valid_reg <= 1'b0;
            mode_reg       <= MODE_HEADER;
            hdr_idx_reg    <= 3'd0;
            page_base_reg  <= 32'd0;
            block_len_reg  <= 32'd0;
            bib_reg        <= 32'd0;
            consumed_reg   <= 33'd0;
            low_reg        <= 8'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                dir_size_reg <= cfg_wdata;
            end
            if (byte_ready)
            begin
                byte_valid_reg <= byte_valid;
            end
            mode_reg      <= mode_next;
            hdr_idx_reg   <= hdr_idx_next;
            page_base_reg <= page_base_next;
            block_len_reg <= block_len_next;
            bib_reg       <= bib_next;
            consumed_reg  <= consumed_next;
            low_reg       <= low_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            byte_reg <= byte_data;
        end
    end

    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_STOPPED |=> mode_reg == MODE_STOPPED)
        else $error("parser left the stopped mode");

    a_idx_in_header: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_idx_reg != 3'd0 |-> mode_reg == MODE_HEADER)
        else $error("header index set outside header mode");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> push.r0.kind == KIND_ENTRY && push.r1.kind == KIND_END
            && mode_next == MODE_STOPPED)
        else $error("two results from one byte out of order");

endmodule

`default_nettype wire

// File: rtl/core/brsp_result_fifo.sv
// small result queue: two writes and one read per cycle, register output
// depends on brsp_pkg; fed by brsp_parser
`default_nettype none

module brsp_result_fifo
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire brsp_pkg::push_t   push,
    output logic                   room,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output brsp_pkg::result_t      out_res
);
    import brsp_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    result_t       mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0] wr_ptr_p1, wr_ptr_p2;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == LAST_PTR) ? '0 : p + PW'(1);
    endfunction

    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != '0;
    assign out_res   = mem_reg[rd_ptr_reg];
    assign room      = count_reg <= CW'(DEPTH - 2);
    assign wr_ptr_p1 = ptr_inc(wr_ptr_reg);
    assign wr_ptr_p2 = ptr_inc(wr_ptr_p1);

    always_comb
    begin
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        case (push.count)
            2'd1:    wr_ptr_next = wr_ptr_p1;
            2'd2:    wr_ptr_next = wr_ptr_p2;
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        count_next = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_p1] <= push.r1;
        end
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> room)
        else $error("result pushed without room");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("result queue overflow");

endmodule

`default_nettype wire

// File: rtl/core/base_relocation_stream_parser_top.sv
// base relocation stream parser: bytes of a relocation directory in, relocation results out
// depends on brsp_pkg, brsp_parser and brsp_result_fifo
//
// usage
//   s_axis carries one directory byte per transaction in tdata[7:0], in address order.
//   m_axis carries one result per transaction: tuser is the result kind (entry, bad
//   block size, end of directory), tdata holds the relocation type and address, tlast
//   marks the final result caused by one input byte.
//   cfg_we/cfg_wdata write the directory size; write it while the stream is idle.
//   A size of zero drops every byte.
// timing
//   one byte per cycle sustained while the result queue has room. a byte is held in an input
//   register and parsed once the queue has room, when its results enter the result queue;
//   they show on m_axis right after that edge when no earlier result waits. the per-byte counter
//   and address add sit between input register and result queue. a byte closing the directory
//   with a final entry gives two results.
// reset and stall
//   reset clears the parse state and the directory size and empties the queue.
//   when m_axis stalls, results wait in a queue of RESULT_DEPTH entries; parsing halts once fewer
//   than two free slots remain, s_axis tready falls while a byte waits, and nothing is lost.
`default_nettype none

module base_relocation_stream_parser_top
#(
    parameter int unsigned RESULT_DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [3:0] reloc_type, [35:4] reloc_address, zero pad
    output logic [1:0]       m_axis_tuser,   // [1:0] result_kind
    output logic             m_axis_tlast
);
    import brsp_pkg::*;

    push_t   push;
    logic    room;
    result_t out_res;

    brsp_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .byte_valid (s_axis_tvalid),
        .byte_ready (s_axis_tready),
        .byte_data  (s_axis_tdata),
        .room       (room),
        .push       (push)
    );

    brsp_result_fifo #(
        .DEPTH (RESULT_DEPTH)
    ) u_result_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {4'd0, out_res.addr, out_res.rtype};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire

// File: test/base_relocation_stream_parser_top_test.sv
// self-checking testbench for base_relocation_stream_parser_top: directory bytes in, results out
// depends on brsp_pkg and the parser top level; carries its own model of the parse state
`default_nettype none

module base_relocation_stream_parser_top_test;

    import brsp_pkg::*;

    typedef enum logic {
        OP_BYTE,
        OP_CFG
    } plan_op_t;

    typedef struct {
        plan_op_t    op;
        logic [31:0] value;
        bit          typed;
        result_t     want;
    } plan_row_t;

    localparam result_t NO_RESULT = '0;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [3:0] reloc_type, [35:4] reloc_address, zero pad
    logic [1:0]  m_axis_tuser;   // [1:0] result_kind
    logic        m_axis_tlast;

    // parse state as the block should hold it
    logic [31:0] dir_size;
    mode_t       mode;
    logic [2:0]  hdr_idx;
    logic [31:0] page_base;
    logic [31:0] blk_len;
    logic [31:0] in_block;
    logic [32:0] consumed;
    logic [7:0]  low_byte;

    result_t     reloc_q[$];
    int          errors = 0;
    int          parsed = 0;
    bit          calm = 1'b0;

    // after reset the size is zero, so the first bytes are dropped
    plan_row_t plan [27] = '{
        '{OP_BYTE, 32'h00, 1'b0, NO_RESULT},
        '{OP_BYTE, 32'hFF, 1'b0, NO_RESULT},
        '{OP_CFG,  32'hFFFF_FFFF, 1'b0, NO_RESULT},
        // page base at the very top, odd block size of 13
        '{OP_BYTE, 32'hFF, 1'b0, NO_RESULT},
        '{OP_BYTE, 32'hFF, 1'b0, NO_RESULT},
        '{OP_BYTE, 32'hFF, 1'b0, NO_RESULT},
        '{OP_BYTE, 32'hFF, 1'b0, NO_RESULT},
        '{OP_BYTE, 32'h0D, 1'b0, NO_RESULT},
        '{OP_BYTE, 32'h00, 1'b0, NO_RESULT},
        '{OP_BYTE, 32'h00, 1'b0, NO_RESULT},
        '{OP_BYTE, 32'h00, 1'b0, NO_RESULT},
        // size dropped to zero mid-block: the byte is ignored, the parse carries on
        '{OP_CFG,  32'h0, 1'b0, NO_RESULT},
        '{OP_BYTE, 32'hA5, 1'b0, NO_RESULT},
        '{OP_CFG,  32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{OP_BYTE, 32'hFF, 1'b0, NO_RESULT},
        '{OP_BYTE, 32'hFF, 1'b1, '{KIND_ENTRY, 4'hF, 32'h0000_0FFE, 1'b1}},
        '{OP_BYTE, 32'h00, 1'b0, NO_RESULT},
        '{OP_BYTE, 32'h00, 1'b1, '{KIND_ENTRY, 4'h0, 32'hFFFF_FFFF, 1'b1}},
        // trailing byte of the odd block
        '{OP_BYTE, 32'h5A, 1'b0, NO_RESULT},
        // header-only block with a zero page base
        '{OP_BYTE, 32'h00, 1'b0, NO_RESULT},
        '{OP_BYTE, 32'h00, 1'b0, NO_RESULT},
        '{OP_BYTE, 32'h00, 1'b0, NO_RESULT},
        '{OP_BYTE, 32'h00, 1'b0, NO_RESULT},
        '{OP_BYTE, 32'h08, 1'b0, NO_RESULT},
        '{OP_BYTE, 32'h00, 1'b0, NO_RESULT},
        '{OP_BYTE, 32'h00, 1'b0, NO_RESULT},
        '{OP_BYTE, 32'h00, 1'b0, NO_RESULT}
    };

    always #5 clk = ~clk;

    base_relocation_stream_parser_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    task automatic report_mismatch(input string what, input logic [35:0] got,
                                   input logic [35:0] want);
        $display("mismatch: %s got %0h want %0h", what, got, want);
        errors++;
    endtask

    // adds a finished block to the running count; returns 1 once the directory is done
    function automatic bit close_block();
        consumed = consumed + {1'b0, blk_len};
        in_block = 32'd0;
        hdr_idx  = 3'd0;
        if (consumed >= {1'b0, dir_size})
        begin
            mode = MODE_STOPPED;
            return 1'b1;
        end
        mode = MODE_HEADER;
        return 1'b0;
    endfunction

    function automatic int parse_byte(input logic [7:0] b, output result_t [1:0] res);
        int         n;
        logic [2:0] idx;
        logic [15:0] word;
        n   = 0;
        res = '0;
        if (dir_size != 32'd0 && mode != MODE_STOPPED)
        begin
            if (mode == MODE_HEADER)
            begin
                idx = hdr_idx;
                if (!idx[2])
                    page_base[idx[1:0] * 8 +: 8] = b;
                else
                    blk_len[idx[1:0] * 8 +: 8] = b;
                in_block = 32'(idx) + 32'd1;
                hdr_idx  = idx + 3'd1;
                if (idx == 3'd7)
                begin
                    if (blk_len < HEADER_BYTES)
                    begin
                        mode   = MODE_STOPPED;
                        res[0] = '{KIND_BAD_SIZE, 4'd0, 32'd0, 1'b0};
                        n      = 1;
                    end
                    else if (blk_len == HEADER_BYTES)
                    begin
                        if (close_block())
                        begin
                            res[0] = '{KIND_END, 4'd0, 32'd0, 1'b0};
                            n      = 1;
                        end
                    end
                    else
                        mode = MODE_ENTRIES;
                end
            end
            else
            begin
                // entry offset within the block has the parity of in_block
                if (!in_block[0])
                    low_byte = b;
                else
                begin
                    word   = {b, low_byte};
                    res[0] = '{KIND_ENTRY, word[15:12], page_base + 32'(word[11:0]), 1'b0};
                    n      = 1;
                end
                in_block++;
                if (in_block == blk_len && close_block())
                begin
                    res[n] = '{KIND_END, 4'd0, 32'd0, 1'b0};
                    n++;
                end
            end
            if (n > 0)
                res[n - 1].last = 1'b1;
        end
        return n;
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit typed, input result_t want);
        result_t [1:0] res;
        int            n;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (dir_size != 32'd0 && mode != MODE_STOPPED)
            parsed++;
        n = parse_byte(b, res);
        if (typed)
            reloc_q.push_back(want);
        else
            for (int i = 0; i < n; i++)
                reloc_q.push_back(res[i]);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // hold off the sender until every result is out and the pipeline is empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (reloc_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_size(input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        dir_size = value;
        cfg_we   <= 1'b0;
    endtask

    task automatic send_block(input logic [31:0] len);
        logic [31:0] base;
        logic [63:0] hdr;
        // a base near the top makes the address add wrap
        base = ($urandom_range(0, 3) == 0) ? {20'hFFFFF, 12'($urandom)} : $urandom;
        hdr  = {len, base};
        for (int i = 0; i < 8; i++)
            send_byte(hdr[i * 8 +: 8], 1'b0, NO_RESULT);
        for (int i = 8; i < int'(len); i++)
            send_byte(8'($urandom), 1'b0, NO_RESULT);
    endtask

    initial
    begin
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (reloc_q.size() == 0)
                report_mismatch("result with nothing pending, kind", 36'(m_axis_tuser), 36'd0);
            else
            begin
                want = reloc_q.pop_front();
                if (m_axis_tuser != want.kind)
                    report_mismatch("result_kind", 36'(m_axis_tuser), 36'(want.kind));
                if (m_axis_tdata[3:0] != want.rtype)
                    report_mismatch("reloc_type", 36'(m_axis_tdata[3:0]), 36'(want.rtype));
                if (m_axis_tdata[35:4] != want.addr)
                    report_mismatch("reloc_address", 36'(m_axis_tdata[35:4]), 36'(want.addr));
                if (m_axis_tlast != want.last)
                    report_mismatch("last", 36'(m_axis_tlast), 36'(want.last));
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        logic [31:0] wide_size;
        logic [31:0] len;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= 32'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        dir_size  = 32'd0;
        mode      = MODE_HEADER;
        hdr_idx   = 3'd0;
        page_base = 32'd0;
        blk_len   = 32'd0;
        in_block  = 32'd0;
        consumed  = 33'd0;
        low_byte  = 8'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].op == OP_CFG)
            begin
                settle();
                write_size(plan[i].value);
            end
            else
                send_byte(plan[i].value[7:0], plan[i].typed, plan[i].want);
        end

        // random blocks; the size, when not zero, stays well above the running count here
        while (parsed < 720)
        begin
            if (parsed > 620)
                calm = 1'b1;
            wide_size = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                                   : ($urandom | 32'h8000_0000);
            case ($urandom_range(0, 9))
                0:
                begin
                    settle();
                    write_size(32'd0);
                    repeat ($urandom_range(1, 8)) send_byte(8'($urandom), 1'b0, NO_RESULT);
                    settle();
                    write_size(wide_size);
                end
                1:
                begin
                    settle();
                    write_size(wide_size);
                end
                default: ;
            endcase
            len = ($urandom_range(0, 7) == 0) ? 32'd8 : 32'($urandom_range(8, 40));
            send_block(len);
        end

        // the parse stops for good on either a bad block size or the end of the directory
        settle();
        if ($urandom_range(0, 1) == 1)
        begin
            len = 32'($urandom_range(8, 30));
            case ($urandom_range(0, 2))
                0:       wide_size = consumed[31:0] + len;
                1:       wide_size = consumed[31:0] + 32'($urandom_range(1, len - 1));
                default: wide_size = 32'($urandom_range(1, consumed[31:0]));
            endcase
            write_size(wide_size);
            send_block(len);
        end
        else
            send_block(32'($urandom_range(0, 7)));
        repeat (8) send_byte(8'($urandom), 1'b0, NO_RESULT);
        s_axis_tvalid <= 1'b0;

        for (int i = 0; i < 5000 && reloc_q.size() != 0; i++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (reloc_q.size() != 0)
            report_mismatch("results never seen, count", 36'(reloc_q.size()), 36'd0);

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
rtl/core/brsp_pkg.sv
rtl/core/brsp_parser.sv
rtl/core/brsp_result_fifo.sv
rtl/core/base_relocation_stream_parser_top.sv
test/base_relocation_stream_parser_top_test.sv
